### rtl/atbl_pkg.sv
`timescale 1ns / 1ps

package atbl_pkg;

   // Table geometry.
   localparam int SLOTS = 16;
   localparam int OWNER_BITS = 8;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Field widths of the request and response words.
   localparam int TIME_W = 32;
   localparam int ID_W = 32;
   localparam int PORT_OWNER_W = 8;
   localparam int COUNT_W = 5;

   // Reset value of the maximum delay register: thirty days in seconds.
   localparam logic [TIME_W-1:0] MAX_DELAY_RESET = TIME_W'(30 * 24 * 60 * 60);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [OWNER_BITS-1:0] owner_type;
   typedef logic [PORT_OWNER_W-1:0] port_owner_type;
   typedef logic [TIME_W-1:0] time_type;
   typedef logic [ID_W-1:0] id_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      CMD_SCHEDULE = 2'd0,
      CMD_CANCEL   = 2'd1,
      CMD_LIST     = 2'd2,
      CMD_TICK     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_REPLY = 2'd0,
      KIND_ENTRY = 2'd1,
      KIND_FIRED = 2'd2,
      KIND_COUNT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_ARG     = 3'd1,
      ST_FULL        = 3'd2,
      ST_NOT_FOUND   = 3'd3,
      ST_UNSUPPORTED = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    load;
      logic    check;
      logic    scan;
      logic    finish;
      idx_type index;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic resolved;
      logic hit;
   } dp_status_type;

endpackage

### rtl/atbl_ctrl.sv
`timescale 1ns / 1ps

module atbl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  atbl_pkg::dp_status_type dp_status,
   output atbl_pkg::ctrl_cmd_type  ctrl_cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   atbl_pkg::idx_type index_ff, index_in;

   // Next state: check the word, walk the slots in order, then close out.
   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            index_in = '0;
            if (dp_status.resolved) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (dp_status.hit) begin
               state_in = S_IDLE;
            end else if (index_ff == atbl_pkg::idx_type'(atbl_pkg::SLOTS - 1)) begin
               state_in = S_FINISH;
            end else begin
               index_in = index_ff + 1'b1;
            end
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         index_ff <= '0;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
      end
   end

   // Commands follow directly from the current state and start.
   assign busy            = (state_ff != S_IDLE);
   assign ctrl_cmd.load   = (state_ff == S_IDLE) && start;
   assign ctrl_cmd.check  = (state_ff == S_CHECK);
   assign ctrl_cmd.scan   = (state_ff == S_SCAN);
   assign ctrl_cmd.finish = (state_ff == S_FINISH);
   assign ctrl_cmd.index  = index_ff;

endmodule

### rtl/atbl_dp.sv
`timescale 1ns / 1ps

module atbl_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  atbl_pkg::ctrl_cmd_type      ctrl_cmd,
   output atbl_pkg::dp_status_type     dp_status,
   input  logic [1:0]                  req_command,
   input  atbl_pkg::time_type          req_now_seconds,
   input  atbl_pkg::time_type          req_alarm_time,
   input  atbl_pkg::id_type            req_alarm_id,
   input  atbl_pkg::port_owner_type    req_owner,
   input  logic                        req_permitted,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  atbl_pkg::time_type          csr_wdata,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_kind,
   output logic [2:0]                  rsp_status,
   output atbl_pkg::id_type            rsp_entry_id,
   output atbl_pkg::time_type          rsp_entry_time,
   output atbl_pkg::port_owner_type    rsp_entry_owner,
   output atbl_pkg::count_type         rsp_entry_count,
   output logic                        rsp_last
);

   // Latched request word.
   atbl_pkg::cmd_type   cmd_ff;
   atbl_pkg::time_type  now_ff;
   atbl_pkg::time_type  atime_ff;
   atbl_pkg::id_type    aid_ff;
   atbl_pkg::owner_type owner_ff;
   logic                perm_ff;

   // Slot table, shared counters and the delay register.
   logic                slot_active_ff [atbl_pkg::SLOTS];
   atbl_pkg::time_type  slot_due_ff    [atbl_pkg::SLOTS];
   atbl_pkg::id_type    slot_id_ff     [atbl_pkg::SLOTS];
   atbl_pkg::owner_type slot_owner_ff  [atbl_pkg::SLOTS];
   atbl_pkg::id_type    next_id_ff, next_id_in;
   atbl_pkg::time_type  last_tick_ff;
   atbl_pkg::time_type  max_delay_ff;
   atbl_pkg::count_type count_ff, count_in;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   atbl_pkg::kind_type       rsp_kind_ff, rsp_kind_in;
   atbl_pkg::status_type     rsp_status_ff, rsp_status_in;
   atbl_pkg::id_type         rsp_id_ff, rsp_id_in;
   atbl_pkg::time_type       rsp_time_ff, rsp_time_in;
   atbl_pkg::port_owner_type rsp_owner_ff, rsp_owner_in;
   atbl_pkg::count_type      rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Slot read at the scan index and the checks on the latched word.
   logic                rd_active;
   atbl_pkg::time_type  rd_due;
   atbl_pkg::id_type    rd_id;
   atbl_pkg::owner_type rd_owner;
   logic                bad_time;
   logic                tick_skip;
   logic                owner_match;
   logic                set_slot;
   logic                clr_slot;
   logic                tick_update;
   logic                resolved;
   logic                hit;

   assign rd_active   = slot_active_ff[ctrl_cmd.index];
   assign rd_due      = slot_due_ff[ctrl_cmd.index];
   assign rd_id       = slot_id_ff[ctrl_cmd.index];
   assign rd_owner    = slot_owner_ff[ctrl_cmd.index];
   assign owner_match = (rd_owner == owner_ff);
   assign bad_time    = (atime_ff <= now_ff) || ((atime_ff - now_ff) > max_delay_ff);
   assign tick_skip   = (now_ff == '0) || (now_ff == last_tick_ff);

   // Decide each response word and the table update for this cycle.
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = atbl_pkg::KIND_REPLY;
      rsp_status_in = atbl_pkg::ST_OK;
      rsp_id_in     = '0;
      rsp_time_in   = '0;
      rsp_owner_in  = '0;
      rsp_count_in  = '0;
      rsp_last_in   = 1'b0;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      set_slot      = 1'b0;
      clr_slot      = 1'b0;
      tick_update   = 1'b0;
      resolved      = 1'b0;
      hit           = 1'b0;

      if (ctrl_cmd.load) begin
         count_in = '0;
      end

      // Checks that settle a command before any slot is looked at.
      if (ctrl_cmd.check) begin
         if (cmd_ff == atbl_pkg::CMD_TICK) begin
            if (tick_skip) begin
               resolved     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = atbl_pkg::KIND_COUNT;
               rsp_last_in  = 1'b1;
            end else begin
               tick_update = 1'b1;
            end
         end else if (!perm_ff) begin
            resolved      = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = atbl_pkg::ST_UNSUPPORTED;
            rsp_last_in   = 1'b1;
         end else if (((cmd_ff == atbl_pkg::CMD_SCHEDULE) && bad_time) ||
                      ((cmd_ff == atbl_pkg::CMD_CANCEL) && (aid_ff == '0))) begin
            resolved      = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = atbl_pkg::ST_BAD_ARG;
            rsp_last_in   = 1'b1;
         end
      end

      // One slot per cycle.
      if (ctrl_cmd.scan) begin
         unique case (cmd_ff)
            atbl_pkg::CMD_SCHEDULE: begin
               if (!rd_active) begin
                  hit          = 1'b1;
                  set_slot     = 1'b1;
                  next_id_in   = (next_id_ff + 1'b1 == '0) ? atbl_pkg::id_type'(1)
                                                           : next_id_ff + 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = next_id_ff;
                  rsp_time_in  = atime_ff;
                  rsp_owner_in = atbl_pkg::port_owner_type'(owner_ff);
                  rsp_last_in  = 1'b1;
               end
            end
            atbl_pkg::CMD_CANCEL: begin
               if (rd_active && (rd_id == aid_ff) && owner_match) begin
                  hit          = 1'b1;
                  clr_slot     = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = rd_id;
                  rsp_time_in  = rd_due;
                  rsp_owner_in = atbl_pkg::port_owner_type'(rd_owner);
                  rsp_last_in  = 1'b1;
               end
            end
            atbl_pkg::CMD_LIST: begin
               if (rd_active && owner_match) begin
                  count_in     = count_ff + 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = atbl_pkg::KIND_ENTRY;
                  rsp_id_in    = rd_id;
                  rsp_time_in  = rd_due;
                  rsp_owner_in = atbl_pkg::port_owner_type'(rd_owner);
               end
            end
            atbl_pkg::CMD_TICK: begin
               if (rd_active && (rd_due <= now_ff)) begin
                  clr_slot     = 1'b1;
                  count_in     = count_ff + 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = atbl_pkg::KIND_FIRED;
                  rsp_id_in    = rd_id;
                  rsp_time_in  = rd_due;
                  rsp_owner_in = atbl_pkg::port_owner_type'(rd_owner);
               end
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end

      // End of the scan without a match, or the closing count.
      if (ctrl_cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         case (cmd_ff)
            atbl_pkg::CMD_SCHEDULE: begin
               rsp_status_in = atbl_pkg::ST_FULL;
            end
            atbl_pkg::CMD_CANCEL: begin
               rsp_status_in = atbl_pkg::ST_NOT_FOUND;
            end
            default: begin
               rsp_kind_in  = atbl_pkg::KIND_COUNT;
               rsp_count_in = count_ff;
            end
         endcase
      end
   end

   assign dp_status.resolved = resolved;
   assign dp_status.hit      = hit;

   // Request capture.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff   <= atbl_pkg::cmd_type'(req_command);
         now_ff   <= req_now_seconds;
         atime_ff <= req_alarm_time;
         aid_ff   <= req_alarm_id;
         owner_ff <= atbl_pkg::owner_type'(req_owner);
         perm_ff  <= req_permitted;
      end
   end

   // Slot payload is written only when a slot is taken.
   always_ff @(posedge clock) begin
      if (set_slot) begin
         slot_due_ff[ctrl_cmd.index]   <= atime_ff;
         slot_id_ff[ctrl_cmd.index]    <= next_id_ff;
         slot_owner_ff[ctrl_cmd.index] <= owner_ff;
      end
   end

   // Active bits, counters and the delay register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < atbl_pkg::SLOTS; i++) begin
            slot_active_ff[i] <= 1'b0;
         end
         next_id_ff   <= atbl_pkg::id_type'(1);
         last_tick_ff <= '0;
         max_delay_ff <= atbl_pkg::MAX_DELAY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (set_slot) begin
            slot_active_ff[ctrl_cmd.index] <= 1'b1;
         end else if (clr_slot) begin
            slot_active_ff[ctrl_cmd.index] <= 1'b0;
         end
         if (tick_update) begin
            last_tick_ff <= now_ff;
         end
         if (csr_valid && csr_ready) begin
            max_delay_ff <= csr_wdata;
         end
         next_id_ff   <= next_id_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign csr_ready       = 1'b1;
   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_id    = rsp_id_ff;
   assign rsp_entry_time  = rsp_time_ff;
   assign rsp_entry_owner = rsp_owner_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### rtl/alarm_table_engine_top.sv
// A rejected command or an idle tick is settled in the check state and its word is
// registered and strobed; otherwise the walk visits one slot per scan state and a closing
// word follows in the finish state. Schedule and cancel stop at their matching slot. A new
// command is taken only once busy has dropped and the block is back in idle.
// Reset clears all active bits at once, so the block is ready the cycle after.
// Response words are strobed for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps

module alarm_table_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_now_seconds,
   input  logic [31:0] req_alarm_time,
   input  logic [31:0] req_alarm_id,
   input  logic [7:0]  req_owner,
   input  logic        req_permitted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_entry_id,
   output logic [31:0] rsp_entry_time,
   output logic [7:0]  rsp_entry_owner,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_last
);

   atbl_pkg::ctrl_cmd_type  ctrl_cmd;
   atbl_pkg::dp_status_type dp_status;

   // Sequencer for the slot walk.
   atbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   // Slot table, request latch and response register.
   atbl_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl_cmd        (ctrl_cmd),
      .dp_status       (dp_status),
      .req_command     (req_command),
      .req_now_seconds (req_now_seconds),
      .req_alarm_time  (req_alarm_time),
      .req_alarm_id    (req_alarm_id),
      .req_owner       (req_owner),
      .req_permitted   (req_permitted),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_status      (rsp_status),
      .rsp_entry_id    (rsp_entry_id),
      .rsp_entry_time  (rsp_entry_time),
      .rsp_entry_owner (rsp_entry_owner),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

endmodule

### verif/tb_alarm_table_engine_top.sv
`timescale 1ns / 1ps

module tb_alarm_table_engine_top;

   localparam int CYCLE_LIMIT = 400000;

   // One expected response word.
   typedef struct {
      atbl_pkg::kind_type       kind;
      atbl_pkg::status_type     status;
      atbl_pkg::id_type         id;
      atbl_pkg::time_type       tm;
      atbl_pkg::port_owner_type who;
      atbl_pkg::count_type      count;
      logic                     fin;
   } alarm_word_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_command;
   logic [31:0] req_now_seconds;
   logic [31:0] req_alarm_time;
   logic [31:0] req_alarm_id;
   logic [7:0] req_owner;
   logic req_permitted;
   logic csr_valid;
   logic csr_ready;
   logic [31:0] csr_wdata;
   logic rsp_strobe;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_status;
   logic [31:0] rsp_entry_id;
   logic [31:0] rsp_entry_time;
   logic [7:0] rsp_entry_owner;
   logic [4:0] rsp_entry_count;
   logic rsp_last;

   // Shadow copy of the alarm table and its registers.
   logic slot_on [atbl_pkg::SLOTS];
   atbl_pkg::time_type slot_due [atbl_pkg::SLOTS];
   atbl_pkg::id_type slot_tag [atbl_pkg::SLOTS];
   atbl_pkg::owner_type slot_who [atbl_pkg::SLOTS];
   atbl_pkg::id_type next_tag;
   atbl_pkg::time_type last_tick;
   atbl_pkg::time_type max_delay;

   alarm_word_type pending_words [$];
   alarm_word_type head_word;
   atbl_pkg::time_type wall_now;
   int idle_pct;
   int errors;
   int cycle_count = 0;

   alarm_table_engine_top u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_now_seconds(req_now_seconds),
      .req_alarm_time(req_alarm_time),
      .req_alarm_id(req_alarm_id),
      .req_owner(req_owner),
      .req_permitted(req_permitted),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata),
      .rsp_strobe(rsp_strobe),
      .rsp_kind(rsp_kind),
      .rsp_status(rsp_status),
      .rsp_entry_id(rsp_entry_id),
      .rsp_entry_time(rsp_entry_time),
      .rsp_entry_owner(rsp_entry_owner),
      .rsp_entry_count(rsp_entry_count),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   // Queue one expected word.
   function automatic void push_word(atbl_pkg::kind_type k, atbl_pkg::status_type s,
                                     atbl_pkg::id_type id, atbl_pkg::time_type tm,
                                     atbl_pkg::owner_type who, atbl_pkg::count_type n,
                                     logic fin);
      alarm_word_type w;
      w.kind = k;
      w.status = s;
      w.id = id;
      w.tm = tm;
      w.who = atbl_pkg::port_owner_type'(who);
      w.count = n;
      w.fin = fin;
      pending_words.push_back(w);
   endfunction

   // Work out the words that one accepted command produces and update the table.
   task automatic predict_alarm_words(input atbl_pkg::cmd_type cmd,
                                      input atbl_pkg::time_type now_s,
                                      input atbl_pkg::time_type due,
                                      input atbl_pkg::id_type aid,
                                      input atbl_pkg::owner_type who, input logic perm);
      atbl_pkg::count_type n;
      logic done;
      n = '0;
      done = 1'b0;
      if (cmd == atbl_pkg::CMD_TICK) begin
         // A tick with a fresh, known time expires every due slot in order.
         if (now_s != 0 && now_s != last_tick) begin
            last_tick = now_s;
            for (int i = 0; i < atbl_pkg::SLOTS; i++) begin
               if (slot_on[i] && slot_due[i] <= now_s) begin
                  slot_on[i] = 1'b0;
                  push_word(atbl_pkg::KIND_FIRED, atbl_pkg::ST_OK, slot_tag[i], slot_due[i],
                            slot_who[i], '0, 1'b0);
                  n = n + 1'b1;
               end
            end
         end
         push_word(atbl_pkg::KIND_COUNT, atbl_pkg::ST_OK, '0, '0, '0, n, 1'b1);
      end else if (!perm) begin
         push_word(atbl_pkg::KIND_REPLY, atbl_pkg::ST_UNSUPPORTED, '0, '0, '0, '0, 1'b1);
      end else begin
         case (cmd)
            atbl_pkg::CMD_SCHEDULE: begin
               if (due <= now_s || due - now_s > max_delay) begin
                  push_word(atbl_pkg::KIND_REPLY, atbl_pkg::ST_BAD_ARG, '0, '0, '0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < atbl_pkg::SLOTS; i++) begin
                     if (!done && !slot_on[i]) begin
                        slot_on[i] = 1'b1;
                        slot_tag[i] = next_tag;
                        slot_due[i] = due;
                        slot_who[i] = who;
                        next_tag = next_tag + 1;
                        if (next_tag == 0) next_tag = 1;
                        push_word(atbl_pkg::KIND_REPLY, atbl_pkg::ST_OK, slot_tag[i], due, who,
                                  '0, 1'b1);
                        done = 1'b1;
                     end
                  end
                  if (!done) begin
                     push_word(atbl_pkg::KIND_REPLY, atbl_pkg::ST_FULL, '0, '0, '0, '0, 1'b1);
                  end
               end
            end
            atbl_pkg::CMD_CANCEL: begin
               if (aid == 0) begin
                  push_word(atbl_pkg::KIND_REPLY, atbl_pkg::ST_BAD_ARG, '0, '0, '0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < atbl_pkg::SLOTS; i++) begin
                     if (!done && slot_on[i] && slot_tag[i] == aid && slot_who[i] == who) begin
                        slot_on[i] = 1'b0;
                        push_word(atbl_pkg::KIND_REPLY, atbl_pkg::ST_OK, slot_tag[i],
                                  slot_due[i], slot_who[i], '0, 1'b1);
                        done = 1'b1;
                     end
                  end
                  if (!done) begin
                     push_word(atbl_pkg::KIND_REPLY, atbl_pkg::ST_NOT_FOUND, '0, '0, '0, '0,
                               1'b1);
                  end
               end
            end
            default: begin
               for (int i = 0; i < atbl_pkg::SLOTS; i++) begin
                  if (slot_on[i] && slot_who[i] == who) begin
                     push_word(atbl_pkg::KIND_ENTRY, atbl_pkg::ST_OK, slot_tag[i], slot_due[i],
                               slot_who[i], '0, 1'b0);
                     n = n + 1'b1;
                  end
               end
               push_word(atbl_pkg::KIND_COUNT, atbl_pkg::ST_OK, '0, '0, '0, n, 1'b1);
            end
         endcase
      end
   endtask

   // Random gap on the command side before the next word is offered.
   task automatic sender_gap();
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Offer one command word and predict its responses once it is taken.
   task automatic send_command(input atbl_pkg::cmd_type cmd, input atbl_pkg::time_type now_s,
                               input atbl_pkg::time_type at, input atbl_pkg::id_type aid,
                               input atbl_pkg::port_owner_type who, input logic perm);
      sender_gap();
      @(negedge clock);
      start = 1'b1;
      req_command = cmd;
      req_now_seconds = now_s;
      req_alarm_time = at;
      req_alarm_id = aid;
      req_owner = who;
      req_permitted = perm;
      do @(posedge clock); while (busy !== 1'b0);
      predict_alarm_words(cmd, now_s, at, aid, atbl_pkg::owner_type'(who), perm);
   endtask

   // Drop start and wait until every response is in and the block is idle.
   task automatic wait_quiet();
      @(negedge clock);
      start = 1'b0;
      while (pending_words.size() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   // Write the maximum delay register while the block is idle.
   task automatic write_max_delay(input atbl_pkg::time_type value);
      wait_quiet();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_wdata = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      max_delay = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Owners come mostly from a small pool so that lists and cancels find entries.
   function automatic atbl_pkg::port_owner_type pick_owner();
      atbl_pkg::port_owner_type pool [4] = '{8'h00, 8'h01, 8'h5A, 8'hFF};
      if ($urandom_range(9) < 6) return pool[$urandom_range(3)];
      return atbl_pkg::port_owner_type'($urandom);
   endfunction

   // Spread of due times that stays close to the wall clock.
   function automatic atbl_pkg::time_type schedule_span();
      if (max_delay == 0) return 1;
      return (max_delay > 4000) ? 4000 : max_delay;
   endfunction

   // One random command, mostly well formed, some pure noise.
   task automatic send_random_command();
      int pick;
      int k;
      int live [$];
      atbl_pkg::time_type now_s;
      atbl_pkg::time_type at;
      atbl_pkg::id_type aid;
      atbl_pkg::port_owner_type who;
      logic perm;
      pick = $urandom_range(99);
      perm = ($urandom_range(99) < 92);
      who = pick_owner();
      if (pick < 8) begin
         send_command(atbl_pkg::cmd_type'($urandom_range(3)), $urandom, $urandom, $urandom,
                      atbl_pkg::port_owner_type'($urandom), 1'($urandom_range(1)));
      end else if (pick < 45) begin
         // Schedule: most due times valid, the rest too early or too late.
         now_s = wall_now + $urandom_range(20);
         k = $urandom_range(99);
         if (k < 80) at = now_s + $urandom_range(schedule_span(), 1);
         else if (k < 90) at = now_s - $urandom_range(50);
         else at = now_s + max_delay + 1 + $urandom_range(50);
         send_command(atbl_pkg::CMD_SCHEDULE, now_s, at, $urandom, who, perm);
      end else if (pick < 62) begin
         // Cancel: usually a live alarm, sometimes with a wrong owner.
         for (int i = 0; i < atbl_pkg::SLOTS; i++) if (slot_on[i]) live.push_back(i);
         if (live.size() != 0 && $urandom_range(3) != 0) begin
            k = live[$urandom_range(live.size() - 1)];
            aid = slot_tag[k];
            who = atbl_pkg::port_owner_type'(slot_who[k]);
            if ($urandom_range(4) == 0) begin
               who = who ^ atbl_pkg::port_owner_type'(1 << $urandom_range(7));
            end
         end else begin
            aid = $urandom_range(next_tag + 2);
         end
         send_command(atbl_pkg::CMD_CANCEL, wall_now, $urandom, aid, who, perm);
      end else if (pick < 75) begin
         send_command(atbl_pkg::CMD_LIST, wall_now, $urandom, $urandom, who, perm);
      end else begin
         // Tick: mostly moves time forward, sometimes unknown or repeated.
         k = $urandom_range(19);
         if (k == 0) begin
            now_s = '0;
         end else if (k < 3) begin
            now_s = last_tick;
         end else begin
            wall_now = wall_now + $urandom_range(400);
            now_s = wall_now;
         end
         send_command(atbl_pkg::CMD_TICK, now_s, $urandom, $urandom, who,
                      1'($urandom_range(1)));
      end
   endtask

   // Reply codes, field extremes and expiry, with the register at reset.
   task automatic test_reply_cases();
      send_command(atbl_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1);
      send_command(atbl_pkg::CMD_LIST, 32'd0, 32'd0, 32'd0, 8'hFF, 1'b0);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd10, 32'd20, 32'd0, 8'h01, 1'b0);
      send_command(atbl_pkg::CMD_CANCEL, 32'd10, 32'd0, 32'd1, 8'h01, 1'b0);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd1000, 32'd1000, 32'd0, 8'hA5, 1'b1);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd1000, 32'd999, 32'd0, 8'hA5, 1'b1);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd1000, 32'd1000 + atbl_pkg::MAX_DELAY_RESET,
                   32'd0, 8'hA5, 1'b1);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd1000, 32'd1001 + atbl_pkg::MAX_DELAY_RESET,
                   32'd0, 8'hA5, 1'b1);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00,
                   1'b1);
      send_command(atbl_pkg::CMD_CANCEL, 32'd0, 32'd0, 32'd0, 8'hA5, 1'b1);
      send_command(atbl_pkg::CMD_CANCEL, 32'd0, 32'd0, 32'd1, 8'h5A, 1'b1);
      send_command(atbl_pkg::CMD_CANCEL, 32'd0, 32'd0, 32'hFFFF_FFFF, 8'hA5, 1'b1);
      send_command(atbl_pkg::CMD_LIST, 32'd0, 32'd0, 32'd0, 8'hA5, 1'b1);
      send_command(atbl_pkg::CMD_CANCEL, 32'd0, 32'd0, 32'd1, 8'hA5, 1'b1);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd100, 32'd105, 32'd0, 8'h03, 1'b1);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd100, 32'd110, 32'd0, 8'h03, 1'b1);
      send_command(atbl_pkg::CMD_TICK, 32'd105, 32'd0, 32'd0, 8'h00, 1'b0);
      send_command(atbl_pkg::CMD_TICK, 32'd105, 32'd0, 32'd0, 8'h00, 1'b1);
      send_command(atbl_pkg::CMD_TICK, 32'd110, 32'd0, 32'd0, 8'h00, 1'b1);
      send_command(atbl_pkg::CMD_TICK, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'hFF, 1'b1);
   endtask

   // Register extremes: zero rejects every schedule, one allows a single second.
   task automatic test_max_delay_register();
      write_max_delay(32'd0);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd0, 32'd1, 32'd0, 8'h01, 1'b1);
      write_max_delay(32'd1);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd0, 32'd1, 32'd0, 8'h01, 1'b1);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd5, 32'd7, 32'd0, 8'h01, 1'b1);
      write_max_delay(32'hFFFF_FFFF);
      send_command(atbl_pkg::CMD_SCHEDULE, 32'd0, 32'hFFFF_FFFF, 32'd0, 8'h80, 1'b1);
      send_command(atbl_pkg::CMD_TICK, 32'd1, 32'd0, 32'd0, 8'h00, 1'b1);
   endtask

   // Fill the table, overflow it, list, expire everything, then random traffic.
   task automatic test_random_traffic(input int pct, input atbl_pkg::time_type delay,
                                      input atbl_pkg::time_type origin, input int items);
      int sent;
      write_max_delay(delay);
      idle_pct = pct;
      wall_now = origin;
      for (int i = 0; i <= atbl_pkg::SLOTS; i++) begin
         send_command(atbl_pkg::CMD_SCHEDULE, wall_now,
                      wall_now + $urandom_range(schedule_span(), 1), $urandom, pick_owner(),
                      1'b1);
      end
      send_command(atbl_pkg::CMD_LIST, wall_now, $urandom, $urandom, pick_owner(), 1'b1);
      wall_now = wall_now + schedule_span();
      send_command(atbl_pkg::CMD_TICK, wall_now, $urandom, $urandom, pick_owner(), 1'b1);
      sent = atbl_pkg::SLOTS + 3;
      while (sent < items) begin
         send_random_command();
         sent++;
      end
   endtask

   // Compare one response field with its expectation.
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Every strobed word is checked against the oldest expectation.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual kind %0d status %0d id %0h",
                     $time, rsp_kind, rsp_status, rsp_entry_id);
            errors++;
         end else begin
            head_word = pending_words.pop_front();
            check_field("kind", head_word.kind, rsp_kind);
            check_field("status", head_word.status, rsp_status);
            check_field("entry_id", head_word.id, rsp_entry_id);
            check_field("entry_time", head_word.tm, rsp_entry_time);
            check_field("entry_owner", head_word.who, rsp_entry_owner);
            check_field("entry_count", head_word.count, rsp_entry_count);
            check_field("last", head_word.fin, rsp_last);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Reset, then the tests in turn, then the final verdict.
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = atbl_pkg::CMD_SCHEDULE;
      req_now_seconds = '0;
      req_alarm_time = '0;
      req_alarm_id = '0;
      req_owner = '0;
      req_permitted = 1'b0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      idle_pct = 0;
      errors = 0;
      wall_now = '0;
      for (int i = 0; i < atbl_pkg::SLOTS; i++) begin
         slot_on[i] = 1'b0;
         slot_due[i] = '0;
         slot_tag[i] = '0;
         slot_who[i] = '0;
      end
      next_tag = 1;
      last_tick = '0;
      max_delay = atbl_pkg::MAX_DELAY_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reply_cases();
      test_max_delay_register();
      test_random_traffic(22, 32'd86400, 32'd1000000 + $urandom_range(32'h0FFF_FFFF), 100);
      test_random_traffic(82, 32'd1, 32'hF000_0000 + $urandom_range(32'h00FF_FFFF), 100);
      test_random_traffic(0, 32'hFFFF_FFFF, $urandom_range(32'h7FFF_FFFF, 1000), 100);

      wait_quiet();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/atbl_pkg.sv
rtl/atbl_ctrl.sv
rtl/atbl_dp.sv
rtl/alarm_table_engine_top.sv
verif/tb_alarm_table_engine_top.sv
